### sv/rth_pkg.sv
// rth_pkg: shared types and constants of the rgb to hsv converter
// item structs for both channels and the word handed along the divider row
// no dependencies
`timescale 1ns / 1ps

package rth_pkg;

    localparam int unsigned C_QBITS = 8;

    localparam logic [7:0] C_HUE_STEP  = 8'd43;
    localparam logic [7:0] C_OFS_RED   = 8'd0;
    localparam logic [7:0] C_OFS_GREEN = 8'd85;
    localparam logic [7:0] C_OFS_BLUE  = 8'd171;
    localparam logic [7:0] C_SAT_SCALE = 8'd255;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] saturation;
        logic [7:0] brightness;
    } t_hsv;

    // one restoring division in flight: partial remainder, low numerator
    // byte that fills up with quotient bits, and the divisor
    typedef struct packed {
        logic [7:0] rem;
        logic [7:0] low;
        logic [7:0] den;
    } t_div;

    typedef struct packed {
        t_div       sat_div;
        t_div       hue_div;
        logic [7:0] base;
        logic       neg;
        logic       grey;
        logic       black;
        logic [7:0] bright;
    } t_word;

endpackage

### sv/rgb_to_hsv_8bit.sv
// rgb_to_hsv_8bit: top level of the 8-bit rgb to hsv converter
// depends on rth_pkg, rth_front, rth_cell, rth_out
`timescale 1ns / 1ps

// usage
// - input channel: i_valid / o_stall carry one rgb pixel item in i_data;
//   an item is taken at a clock edge with i_valid high and o_stall low
// - output channel: o_valid / i_stall carry one hsv item in o_data;
//   one result item per input item, in order
// - stages: one front stage (max, min, sector, numerators),
//   a row of 8 divider cells (one quotient bit of both the saturation and
//   the hue division per cell), and the output register
// - throughput one item per clock while no stall holds the row; every stage
//   holds an item of its own, so new pixels enter while older ones are in flight
// - when the receiver stalls, the last stage holds its item and the stall
//   ripples back only through full stages; empty stages still fill, so
//   o_stall rises only once the whole row is occupied
// - reset (synchronous, active low) drops every stage's valid flag;
//   payload registers keep whatever they held

module rgb_to_hsv_8bit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  rth_pkg::t_rgb i_data,
    output logic          o_stall,
    output logic          o_valid,
    output rth_pkg::t_hsv o_data,
    input  logic          i_stall
);
    import rth_pkg::*;

    // stage k of the cell row sees chain_*[k] at its input
    logic  chain_valid [C_QBITS+1];
    t_word chain_data  [C_QBITS+1];
    logic  chain_ready [C_QBITS+1];
    logic  front_ready;

    // front: channel max/min, sector offset, 255*span and 43*|diff|
    rth_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_ready (front_ready),
        .o_valid (chain_valid[0]),
        .o_data  (chain_data[0]),
        .i_ready (chain_ready[0])
    );

    assign o_stall = !front_ready;

    // row of identical divider cells, msb of the quotient first
    for (genvar k = 0; k < C_QBITS; k++) begin : g_cell
        rth_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[k]),
            .i_data  (chain_data[k]),
            .o_ready (chain_ready[k]),
            .o_valid (chain_valid[k+1]),
            .o_data  (chain_data[k+1]),
            .i_ready (chain_ready[k+1])
        );
    end

    // output register: hue sign and offset, black and grey pixels
    rth_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (chain_valid[C_QBITS]),
        .i_data  (chain_data[C_QBITS]),
        .o_ready (chain_ready[C_QBITS]),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_ready (!i_stall)
    );

endmodule

### sv/rth_front.sv
// rth_front: first stage, channel max/min, sector choice and numerators
// depends on rth_pkg
`timescale 1ns / 1ps

module rth_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  rth_pkg::t_rgb i_data,
    output logic          o_ready,
    output logic          o_valid,
    output rth_pkg::t_word o_data,
    input  logic          i_ready
);
    import rth_pkg::*;

    logic       r_valid;
    t_word      r_data;
    t_word      n_data;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] span;
    logic [8:0] diff;
    logic [7:0] mag;
    logic [15:0] sat_num;
    logic [15:0] hue_num;

    always_comb begin
        if (i_data.red >= i_data.green && i_data.red >= i_data.blue) begin
            hi          = i_data.red;
            n_data.base = C_OFS_RED;
            diff        = {1'b0, i_data.green} - {1'b0, i_data.blue};
        end else if (i_data.green >= i_data.blue) begin
            hi          = i_data.green;
            n_data.base = C_OFS_GREEN;
            diff        = {1'b0, i_data.blue} - {1'b0, i_data.red};
        end else begin
            hi          = i_data.blue;
            n_data.base = C_OFS_BLUE;
            diff        = {1'b0, i_data.red} - {1'b0, i_data.green};
        end
        lo = i_data.red;
        if (i_data.green < lo) begin
            lo = i_data.green;
        end
        if (i_data.blue < lo) begin
            lo = i_data.blue;
        end
        span = hi - lo;
        mag  = diff[8] ? 8'(-diff) : diff[7:0];
        // 255 * span, then 43 * |diff|
        sat_num = 16'({8'd0, span} * {8'd0, C_SAT_SCALE});
        hue_num = 16'({8'd0, mag} * {8'd0, C_HUE_STEP});

        n_data.sat_div = '{rem: sat_num[15:8], low: sat_num[7:0], den: hi};
        n_data.hue_div = '{rem: hue_num[15:8], low: hue_num[7:0], den: span};
        n_data.neg     = diff[8];
        n_data.grey    = (span == 8'd0);
        n_data.black   = (hi == 8'd0);
        n_data.bright  = hi;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### sv/rth_cell.sv
// rth_cell: one divider cell, settles one quotient bit of both divisions
// depends on rth_pkg
`timescale 1ns / 1ps

module rth_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  rth_pkg::t_word i_data,
    output logic           o_ready,
    output logic           o_valid,
    output rth_pkg::t_word o_data,
    input  logic           i_ready
);
    import rth_pkg::*;

    logic  r_valid;
    t_word r_data;
    t_word n_data;

    // restoring step: bring down the next numerator bit, subtract if it fits
    function automatic t_div div_step(input t_div d);
        t_div       res;
        logic [8:0] trial;
        logic [8:0] diff;
        trial = {d.rem, d.low[7]};
        diff  = trial - {1'b0, d.den};
        res.den = d.den;
        if (trial >= {1'b0, d.den}) begin
            res.rem = diff[7:0];
            res.low = {d.low[6:0], 1'b1};
        end else begin
            res.rem = trial[7:0];
            res.low = {d.low[6:0], 1'b0};
        end
        return res;
    endfunction

    always_comb begin
        n_data         = i_data;
        n_data.sat_div = div_step(i_data.sat_div);
        n_data.hue_div = div_step(i_data.hue_div);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### sv/rth_out.sv
// rth_out: output register, applies the hue sign and the black/grey cases
// depends on rth_pkg
`timescale 1ns / 1ps

module rth_out (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  rth_pkg::t_word i_data,
    output logic           o_ready,
    output logic           o_valid,
    output rth_pkg::t_hsv  o_data,
    input  logic           i_ready
);
    import rth_pkg::*;

    logic r_valid;
    t_hsv r_data;
    t_hsv n_data;

    always_comb begin
        n_data.brightness = i_data.bright;
        n_data.saturation = i_data.black ? 8'd0 : i_data.sat_div.low;
        if (i_data.grey) begin
            n_data.hue = 8'd0;
        end else if (i_data.neg) begin
            n_data.hue = i_data.base - i_data.hue_div.low;
        end else begin
            n_data.hue = i_data.base + i_data.hue_div.low;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### bench/rth_hsv_checker.sv
// rth_hsv_checker: watches both channels of the rgb to hsv converter
// predicts one hsv item per accepted pixel and compares each result in order
// depends on rth_pkg
`timescale 1ns / 1ps

module rth_hsv_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_pix_valid,
    input  logic          i_pix_stall,
    input  rth_pkg::t_rgb i_pix_data,
    input  logic          i_hsv_valid,
    input  logic          i_hsv_stall,
    input  rth_pkg::t_hsv i_hsv_data,
    output int            o_mismatches,
    output int            o_outstanding
);

    import rth_pkg::*;

    typedef struct {
        t_rgb pixel;
        t_hsv hsv;
    } t_due;

    t_due hsv_due[$];

    // integer hsv of one pixel, hue quotient truncated toward zero
    function automatic t_hsv hsv_of(input t_rgb px);
        int   r;
        int   g;
        int   b;
        int   hi;
        int   lo;
        int   span;
        int   diff;
        int   sector;
        int   acc;
        t_hsv res;
        r = int'(px.red);
        g = int'(px.green);
        b = int'(px.blue);
        hi = (r > g) ? r : g;
        hi = (hi > b) ? hi : b;
        lo = (r < g) ? r : g;
        lo = (lo < b) ? lo : b;
        span = hi - lo;
        res = '0;
        acc = hi;
        res.brightness = acc[7:0];
        if (hi != 0) begin
            acc = (int'(C_SAT_SCALE) * span) / hi;
            res.saturation = acc[7:0];
            if (acc != 0) begin
                // ties go to red first, then green
                if (hi == r) begin
                    sector = int'(C_OFS_RED);
                    diff = g - b;
                end else if (hi == g) begin
                    sector = int'(C_OFS_GREEN);
                    diff = b - r;
                end else begin
                    sector = int'(C_OFS_BLUE);
                    diff = r - g;
                end
                acc = sector + (int'(C_HUE_STEP) * diff) / span;
                res.hue = acc[7:0];
            end
        end
        return res;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got, input t_rgb px);
        if (got !== want) begin
            $display("%0t: %s of pixel %h/%h/%h: expected %0d, actual %0d",
                     $time, name, px.red, px.green, px.blue, want, got);
            o_mismatches++;
        end
    endtask

    initial begin
        o_mismatches = 0;
        o_outstanding = 0;
    end

    always @(posedge i_clk) begin : track
        t_due entry;
        if (i_rst_n) begin
            if (i_pix_valid && !i_pix_stall) begin
                entry.pixel = i_pix_data;
                entry.hsv = hsv_of(i_pix_data);
                hsv_due.push_back(entry);
            end
            if (i_hsv_valid && !i_hsv_stall) begin
                if (hsv_due.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual %h/%h/%h",
                             $time, i_hsv_data.hue, i_hsv_data.saturation,
                             i_hsv_data.brightness);
                    o_mismatches++;
                end else begin
                    entry = hsv_due.pop_front();
                    check_field("hue", entry.hsv.hue, i_hsv_data.hue, entry.pixel);
                    check_field("saturation", entry.hsv.saturation,
                                i_hsv_data.saturation, entry.pixel);
                    check_field("brightness", entry.hsv.brightness,
                                i_hsv_data.brightness, entry.pixel);
                end
            end
            o_outstanding = hsv_due.size();
        end
    end

endmodule

### bench/tb_rgb_to_hsv_8bit.sv
// tb_rgb_to_hsv_8bit: stimulus and verdict for the rgb to hsv converter
// drives corner pixels then a mix of random ones under random idling
// depends on rth_pkg, rgb_to_hsv_8bit, rth_hsv_checker
`timescale 1ns / 1ps

module tb_rgb_to_hsv_8bit;

    import rth_pkg::*;

    // random pixels after the corner cases, and how many of them run with no idling
    localparam int unsigned C_RANDOM_PIXELS = 1027;
    localparam int unsigned C_CALM_PIXELS   = 150;
    // cycles with no item moving on either channel before the run is given up
    localparam int unsigned C_QUIET_LIMIT   = 400;
    // cycles to wait once nothing is outstanding, a little over the pipe latency
    localparam int unsigned C_TAIL_CYCLES   = 14;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_valid;
    t_rgb i_data;
    logic o_stall;
    logic o_valid;
    t_hsv o_data;
    logic i_stall;

    int          mismatches;
    int          outstanding;
    bit          calm = 1'b0;
    int unsigned quiet_cycles = 0;

    // corner pixels, red/green/blue in one word
    logic [23:0] corner_pixels [0:22] = '{
        24'h000000,     // black
        24'hffffff,     // white, grey at the top
        24'h808080,     // mid grey
        24'h010101,     // darkest grey
        24'hff0000,     // pure red
        24'h00ff00,     // pure green
        24'h0000ff,     // pure blue
        24'hffff00,     // red and green tie, red wins
        24'h00ffff,     // green and blue tie, green wins
        24'hff00ff,     // red and blue tie, red wins
        24'hc8c864,     // lower red and green tie
        24'hff00c8,     // red largest, negative difference, hue wraps
        24'hc8ff00,     // green largest, negative difference
        24'h00c8ff,     // blue largest, negative difference
        24'hffc800,     // red largest, positive difference
        24'h6400ff,     // blue largest, positive difference
        24'h010000,     // smallest span
        24'hfffefe,     // span of one under a full maximum
        24'hfeffff,     // green and blue tie over a lower red
        24'h000100,     // faint green
        24'h000001,     // faint blue
        24'haa5500,     // red largest, mid hue
        24'h8040c0      // blue largest, spread channels
    };

    rgb_to_hsv_8bit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    rth_hsv_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pix_valid   (i_valid),
        .i_pix_stall   (o_stall),
        .i_pix_data    (i_data),
        .i_hsv_valid   (o_valid),
        .i_hsv_stall   (i_stall),
        .i_hsv_data    (o_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // a channel level a few steps either side of a grey level, clamped to 8 bits
    function automatic logic [7:0] near_level(input int level);
        int v;
        v = level + int'($urandom_range(0, 6)) - 3;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    // mix of fully random pixels and the shapes that stress the divisions:
    // near grey (tiny span), ties for the maximum, very dark, saturated extremes
    function automatic t_rgb random_pixel();
        t_rgb        px;
        int unsigned pick;
        int unsigned level;
        pick = $urandom_range(0, 99);
        level = $urandom_range(0, 255);
        px.red = 8'($urandom_range(0, 255));
        px.green = 8'($urandom_range(0, 255));
        px.blue = 8'($urandom_range(0, 255));
        if (pick < 40) begin
            // fully random, already set
        end else if (pick < 60) begin
            px.red = near_level(level);
            px.green = near_level(level);
            px.blue = near_level(level);
        end else if (pick < 75) begin
            // two channels share the maximum, the third sits at or below it
            case ($urandom_range(0, 2))
                0: begin
                    px.red = 8'(level);
                    px.green = 8'(level);
                    px.blue = 8'($urandom_range(0, level));
                end
                1: begin
                    px.green = 8'(level);
                    px.blue = 8'(level);
                    px.red = 8'($urandom_range(0, level));
                end
                default: begin
                    px.red = 8'(level);
                    px.blue = 8'(level);
                    px.green = 8'($urandom_range(0, level));
                end
            endcase
        end else if (pick < 85) begin
            px.red = 8'($urandom_range(0, 3));
            px.green = 8'($urandom_range(0, 3));
            px.blue = 8'($urandom_range(0, 3));
        end else if (pick < 95) begin
            // channels pinned to the rails, some left random
            if ($urandom_range(0, 2) == 0) px.red = $urandom_range(0, 1) ? 8'hff : 8'h00;
            if ($urandom_range(0, 2) == 0) px.green = $urandom_range(0, 1) ? 8'hff : 8'h00;
            if ($urandom_range(0, 2) == 0) px.blue = $urandom_range(0, 1) ? 8'hff : 8'h00;
        end else begin
            px.red = 8'(level);
            px.green = 8'(level);
            px.blue = 8'(level);
        end
        return px;
    endfunction

    // idle burst before the next item, none once the run has gone calm
    function automatic int unsigned next_gap();
        if (!calm && $urandom_range(0, 4) == 0) return $urandom_range(1, 14);
        return 0;
    endfunction

    // present one pixel and hold it until the converter takes it;
    // o_stall read straight after the edge is the value the edge saw
    task automatic push_pixel(input t_rgb px, input int unsigned gap);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= px;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // sender side: reset, corner pixels, random pixels, then drain and verdict
    initial begin : stimulus
        int unsigned n;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (corner_pixels[k]) push_pixel(corner_pixels[k], next_gap());

        for (n = 0; n < C_RANDOM_PIXELS; n++) begin
            // final stretch runs back to back on both sides
            if (n == C_RANDOM_PIXELS - C_CALM_PIXELS) calm = 1'b1;
            push_pixel(random_pixel(), next_gap());
        end
        i_valid <= 1'b0;

        // every result in, then a few more cycles to catch any stray item
        while (outstanding != 0) @(posedge i_clk);
        repeat (C_TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // receiver side: random stall bursts between free-running stretches, none once calm
    initial begin : receiver
        i_stall <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 2) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
    end

    // watchdog: gives up when neither channel has moved an item for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= C_QUIET_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

endmodule
